[hdl/didset_pkg.sv]
// ----------------------------------------------------------------------------
// didset_pkg
// Shared types and codes for the identifier set table.
// ----------------------------------------------------------------------------
package didset_pkg;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned IdW     = 32;
  localparam int unsigned IndexW  = 6;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PosW    = 6;
  localparam int unsigned CountW  = 7;

  // Operation codes
  localparam logic [FuncW-1:0] FuncAdd   = 2'd0;
  localparam logic [FuncW-1:0] FuncCheck = 2'd1;
  localparam logic [FuncW-1:0] FuncGet   = 2'd2;
  localparam logic [FuncW-1:0] FuncClear = 2'd3;

  // Result status codes
  localparam logic [StatusW-1:0] StatusOk      = 2'd0;
  localparam logic [StatusW-1:0] StatusPresent = 2'd1;
  localparam logic [StatusW-1:0] StatusFull    = 2'd2;
  localparam logic [StatusW-1:0] StatusMissing = 2'd3;

  typedef struct packed {
    logic [FuncW-1:0]  func;
    logic [IdW-1:0]    ident;
    logic [IndexW-1:0] index;
  } didset_in_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [PosW-1:0]    position;
    logic [IdW-1:0]     chunk_value;
    logic [CountW-1:0]  element_count;
  } didset_out_t;

endpackage

[hdl/didset_ram.sv]
// ----------------------------------------------------------------------------
// didset_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module didset_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/dedup_id_set_table_unit.sv]
// ----------------------------------------------------------------------------
// dedup_id_set_table_unit
// Insertion-ordered set of 32-bit identifiers with linear search.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o / in_data_i) carries one operation:
// add, check, get by index or clear. Output channel (out_valid_o /
// out_ready_i / out_data_o) returns exactly one result per operation with
// status, match position, read value and the element count afterwards.
// Entries live in one RAM with a registered read. Add and check stream
// through the stored entries one per cycle and stop at the first match; on
// an empty set they read no entry. Get reads only the indexed entry and
// clear reads none. The search over the RAM read port takes one operation
// at a time, accepting no new one while a search is under way.
// The output register frees the search engine: a new operation is taken as
// soon as the previous result has moved into it, even if the receiver stalls.
// A finished result waits in the engine until the output register frees up.
// Reset empties the set (count to zero); RAM contents are not cleared, and
// entries at or beyond the count are never read.
// ----------------------------------------------------------------------------
module dedup_id_set_table_unit #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  didset_pkg::didset_in_t   in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output didset_pkg::didset_out_t  out_data_o
);

  import didset_pkg::*;

  localparam int unsigned AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SScan = 2'd1;
  localparam logic [1:0] SGet  = 2'd2;
  localparam logic [1:0] SDone = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [AddrW-1:0] cmp_idx_q, cmp_idx_d;
  logic [IdW-1:0]   key_q, key_d;
  logic [FuncW-1:0] op_q, op_d;
  didset_out_t      res_q, res_d;
  didset_out_t      out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [IdW-1:0]   rd_data;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [IdW-1:0]   wr_data;

  logic             in_acc;
  logic             do_hit, do_miss;
  logic [FuncW-1:0] op_sel;
  logic [IdW-1:0]   key_sel;
  logic             scan_last;

  assign in_ready_o = (state_q == SIdle);
  assign in_acc     = in_valid_i && in_ready_o;

  // Entry under compare is the last stored one
  assign scan_last = ((CntW'(cmp_idx_q) + CntW'(1)) == count_q);

  assign op_sel  = (state_q == SIdle) ? in_data_i.func : op_q;
  assign key_sel = (state_q == SIdle) ? in_data_i.ident : key_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    cmp_idx_d   = cmp_idx_q;
    key_d       = key_q;
    op_d        = op_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = count_q[AddrW-1:0];
    wr_data     = key_sel;
    do_hit      = 1'b0;
    do_miss     = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          key_d                = in_data_i.ident;
          op_d                 = in_data_i.func;
          res_d.status         = StatusOk;
          res_d.position       = '0;
          res_d.chunk_value    = '0;
          res_d.element_count  = CountW'(count_q);
          unique case (in_data_i.func) inside
            FuncAdd, FuncCheck: begin
              if (count_q == '0) begin
                do_miss = 1'b1;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                cmp_idx_d = '0;
                state_d   = SScan;
              end
            end
            FuncGet: begin
              if (32'(in_data_i.index) < 32'(count_q)) begin
                rd_en   = 1'b1;
                rd_addr = AddrW'(in_data_i.index);
                state_d = SGet;
              end else begin
                res_d.status = StatusMissing;
                state_d      = SDone;
              end
            end
            default: begin
              count_d             = '0;
              res_d.element_count = '0;
              state_d             = SDone;
            end
          endcase
        end
      end
      SScan: begin
        if (rd_data == key_q) begin
          do_hit = 1'b1;
        end else if (scan_last) begin
          do_miss = 1'b1;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = cmp_idx_q + AddrW'(1);
          cmp_idx_d = cmp_idx_q + AddrW'(1);
        end
      end
      SGet: begin
        res_d.chunk_value = rd_data;
        state_d           = SDone;
      end
      SDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase

    if (do_hit) begin
      res_d.status        = (op_sel == FuncAdd) ? StatusPresent : StatusOk;
      res_d.position      = PosW'(cmp_idx_q);
      res_d.chunk_value   = '0;
      res_d.element_count = CountW'(count_q);
      state_d             = SDone;
    end

    if (do_miss) begin
      res_d.position      = '0;
      res_d.chunk_value   = '0;
      res_d.element_count = CountW'(count_q);
      if (op_sel == FuncCheck) begin
        res_d.status = StatusMissing;
      end else if (count_q == CntW'(CAPACITY)) begin
        res_d.status = StatusFull;
      end else begin
        // Append at the tail
        wr_en               = 1'b1;
        count_d             = count_q + CntW'(1);
        res_d.status        = StatusOk;
        res_d.position      = PosW'(count_q);
        res_d.element_count = CountW'(count_d);
      end
      state_d = SDone;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    key_q     <= key_d;
    op_q      <= op_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  didset_ram #(
    .Width (IdW),
    .Depth (CAPACITY)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Count never exceeds the table size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count beyond capacity");

  // A write only lands on a free slot
  a_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> count_q < CntW'(CAPACITY))
    else $error("write into a full table");

  // The scan never reads past the stored entries
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && state_q == SScan) |-> CntW'(rd_addr) < count_q)
    else $error("scan read beyond count");

  // Clear empties the set in the next cycle
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.func == FuncClear) |=> (count_q == '0 && state_q == SDone))
    else $error("clear did not empty the set");

endmodule

[verif/dedup_id_set_table_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dedup_id_set_table_unit_tb
// Self-checking test of the identifier set table. A directed opening covers
// empty-set lookups, duplicate adds, misses, out-of-range gets and clears.
// It is followed by random episodes: full-table fills and mixed add, check,
// get and clear traffic over small key pools so that hits are common. Each
// accepted operation updates a local copy of the set, and every result is
// compared field by field, in order, with the predicted one.
// ----------------------------------------------------------------------------
module dedup_id_set_table_unit_tb;
  import didset_pkg::*;

  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned RandomOps   = 1400;
  localparam int unsigned StallLimit  = 5000;
  localparam int unsigned DrainCycles = CAPACITY + 16;

  typedef struct {
    didset_in_t op;
    bit         drain_first;  // hold until every result is back
  } pending_op_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  didset_in_t  in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  didset_out_t out_data;

  pending_op_t op_queue[$];
  didset_out_t expected_results[$];
  int          total_ops    = 0;
  int          issued_cnt   = 0;
  int          accepted_cnt = 0;
  int          err_count    = 0;
  int          stall_cycles = 0;

  // local copy of the set contents
  logic [IdW-1:0]    set_ids [CAPACITY];
  logic [CountW-1:0] set_count = '0;

  dedup_id_set_table_unit #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #5 clk = ~clk;

  function automatic didset_out_t apply_set_op(didset_in_t op);
    didset_out_t r;
    int          hit;
    r   = '0;
    hit = -1;
    for (int i = 0; i < set_count; i++) begin
      if (hit < 0 && set_ids[i] == op.ident) hit = i;
    end
    case (op.func)
      FuncAdd: begin
        if (hit >= 0) begin
          r.status   = StatusPresent;
          r.position = PosW'(hit);
        end else if (set_count >= CAPACITY) begin
          r.status = StatusFull;
        end else begin
          set_ids[set_count] = op.ident;
          r.position = PosW'(set_count);
          set_count++;
        end
      end
      FuncCheck: begin
        if (hit >= 0) r.position = PosW'(hit);
        else r.status = StatusMissing;
      end
      FuncGet: begin
        if (op.index < set_count) r.chunk_value = set_ids[op.index];
        else r.status = StatusMissing;
      end
      default: begin
        set_count = '0;
      end
    endcase
    r.element_count = set_count;
    return r;
  endfunction

  // idle percentage for the current phase of the run
  function automatic int idle_pct_for(bit receiver_side);
    if (accepted_cnt < total_ops / 3) return receiver_side ? 72 : 21;
    if (accepted_cnt < 2 * total_ops / 3) return receiver_side ? 21 : 72;
    return 0;
  endfunction

  task automatic check_field(input string name, input logic [IdW-1:0] want,
                             input logic [IdW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      err_count++;
    end
  endtask

  task automatic queue_op(input logic [FuncW-1:0] f, input logic [IdW-1:0] id,
                          input logic [IndexW-1:0] idx, input bit drain_first);
    pending_op_t p;
    p.op.func     = f;
    p.op.ident    = id;
    p.op.index    = idx;
    p.drain_first = drain_first;
    op_queue.push_back(p);
  endtask

  // sender: new transaction only when the bus slot is free
  always @(negedge clk) begin : driver
    logic        next_valid;
    didset_in_t  next_data;
    pending_op_t p;
    next_valid = in_valid;
    next_data  = in_data;
    if (rst_n && (!in_valid || accepted_cnt == issued_cnt)) begin
      next_valid = 1'b0;
      if (op_queue.size() != 0 &&
          !(op_queue[0].drain_first && expected_results.size() != 0) &&
          $urandom_range(0, 99) >= idle_pct_for(1'b0)) begin
        p          = op_queue.pop_front();
        next_data  = p.op;
        next_valid = 1'b1;
        issued_cnt++;
      end
    end
    in_valid <= next_valid;
    in_data  <= next_data;
  end

  always @(negedge clk) begin : receiver
    out_ready <= rst_n && ($urandom_range(0, 99) >= idle_pct_for(1'b1));
  end

  always @(posedge clk) begin : monitor
    didset_out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, got %0h", $time, out_data);
          err_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", IdW'(want.status), IdW'(out_data.status));
          check_field("position", IdW'(want.position), IdW'(out_data.position));
          check_field("chunk_value", want.chunk_value, out_data.chunk_value);
          check_field("element_count", IdW'(want.element_count),
                      IdW'(out_data.element_count));
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_set_op(in_data));
        accepted_cnt <= accepted_cnt + 1;
      end
      if ((out_valid && out_ready) || (in_valid && in_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, StallLimit);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [IdW-1:0] fill_keys [CAPACITY];
    logic [IdW-1:0] pool [6];
    int             episode;
    int             len;
    int             r;

    // directed opening
    queue_op(FuncGet, 32'h0, 6'd0, 1'b0);            // get on empty set
    queue_op(FuncCheck, 32'h0, 6'd0, 1'b0);          // check on empty set
    queue_op(FuncAdd, 32'h0, 6'd63, 1'b0);
    queue_op(FuncAdd, 32'hFFFF_FFFF, 6'd0, 1'b0);
    queue_op(FuncAdd, 32'h0, 6'd0, 1'b0);            // already present
    queue_op(FuncCheck, 32'hFFFF_FFFF, 6'd0, 1'b0);
    queue_op(FuncCheck, 32'h1234_5678, 6'd0, 1'b0);  // miss
    queue_op(FuncGet, 32'h0, 6'd0, 1'b0);
    queue_op(FuncGet, 32'h0, 6'd1, 1'b0);
    queue_op(FuncGet, 32'h0, 6'd2, 1'b0);            // index equal to count
    queue_op(FuncGet, 32'hFFFF_FFFF, 6'd63, 1'b0);
    queue_op(FuncAdd, 32'hA5A5_A5A5, 6'd0, 1'b0);
    queue_op(FuncAdd, 32'h5A5A_5A5A, 6'd0, 1'b0);
    queue_op(FuncCheck, 32'h5A5A_5A5A, 6'd0, 1'b0);
    queue_op(FuncAdd, 32'hFFFF_FFFF, 6'd0, 1'b0);    // present, not at head
    queue_op(FuncClear, 32'hFFFF_FFFF, 6'd63, 1'b1);
    queue_op(FuncCheck, 32'h0, 6'd0, 1'b0);          // stale entry must miss
    queue_op(FuncGet, 32'h0, 6'd0, 1'b0);
    queue_op(FuncAdd, 32'hFFFF_FFFF, 6'd0, 1'b0);
    queue_op(FuncClear, 32'h0, 6'd0, 1'b0);
    queue_op(FuncClear, 32'h0, 6'd0, 1'b0);          // clear when already empty

    episode = 0;
    while (op_queue.size() < RandomOps) begin
      if (episode == 0 || $urandom_range(0, 7) == 0) begin
        // fill to capacity, then hit the full table
        queue_op(FuncClear, $urandom, IndexW'($urandom), $urandom_range(0, 3) == 0);
        for (int i = 0; i < CAPACITY; i++) begin
          fill_keys[i] = $urandom;
          queue_op(FuncAdd, fill_keys[i], IndexW'($urandom), 1'b0);
        end
        repeat (4) queue_op(FuncAdd, $urandom, IndexW'($urandom), 1'b0);
        repeat (4) queue_op(FuncAdd, fill_keys[$urandom_range(0, CAPACITY - 1)],
                            IndexW'($urandom), 1'b0);
        queue_op(FuncCheck, fill_keys[CAPACITY - 1], IndexW'($urandom), 1'b0);
        repeat (5) queue_op(FuncCheck, fill_keys[$urandom_range(0, CAPACITY - 1)],
                            IndexW'($urandom), 1'b0);
        queue_op(FuncGet, $urandom, IndexW'(CAPACITY - 1), 1'b0);
        repeat (5) queue_op(FuncGet, $urandom, IndexW'($urandom), 1'b0);
      end else begin
        // mixed traffic over a small key pool
        foreach (pool[k]) begin
          r = $urandom_range(0, 99);
          pool[k] = (r < 8) ? '0 : (r < 16) ? '1 : $urandom;
        end
        len = $urandom_range(10, 30);
        repeat (len) begin
          r = $urandom_range(0, 99);
          if (r < 40) begin
            queue_op(FuncAdd, pool[$urandom_range(0, 5)], IndexW'($urandom), 1'b0);
          end else if (r < 62) begin
            queue_op(FuncCheck, pool[$urandom_range(0, 5)], IndexW'($urandom), 1'b0);
          end else if (r < 70) begin
            queue_op(FuncCheck, $urandom, IndexW'($urandom), 1'b0);
          end else if (r < 84) begin
            queue_op(FuncGet, $urandom, IndexW'($urandom_range(0, 15)), 1'b0);
          end else if (r < 90) begin
            queue_op(FuncGet, $urandom, IndexW'($urandom), 1'b0);
          end else if (r < 96) begin
            queue_op(FuncAdd, $urandom, IndexW'($urandom), 1'b0);
          end else begin
            queue_op(FuncClear, $urandom, IndexW'($urandom), $urandom_range(0, 1) == 0);
          end
        end
      end
      episode++;
    end
    total_ops = op_queue.size();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (accepted_cnt < total_ops || expected_results.size() != 0);
    repeat (DrainCycles) @(negedge clk);

    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/didset_pkg.sv
hdl/didset_ram.sv
hdl/dedup_id_set_table_unit.sv
verif/dedup_id_set_table_unit_tb.sv
